FILE: rtl/b2da_pkg.sv
package b2da_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned CharW     = 6;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned ConvSteps = ValueW;
  localparam int unsigned CntW      = $clog2(ConvSteps);

  localparam logic [CntW-1:0]   ConvLast  = CntW'(ConvSteps - 1);
  localparam logic [CntW-1:0]   EmitLast  = CntW'(NumDigits - 1);
  localparam logic [CharW-1:0]  CharZero  = 6'd48;
  localparam logic [CharW-1:0]  CharNine  = 6'd57;
  localparam logic [CharW-1:0]  CharMinus = 6'd45;
  localparam logic [DigitW-1:0] AdjLimit  = 4'd5;
  localparam logic [DigitW-1:0] AdjAdd    = 4'd3;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_signed;
  } b2da_in_t;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             last;
  } b2da_out_t;

  typedef struct packed {
    logic clr;
    logic conv;
    logic emit;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } b2da_state_e;

endpackage

FILE: rtl/b2da_cell.sv
module b2da_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  b2da_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        bit_i,
  input  logic [b2da_pkg::DigitW-1:0] digit_i,
  output logic                        bit_o,
  output logic [b2da_pkg::DigitW-1:0] digit_o
);

  logic [b2da_pkg::DigitW-1:0] digit_q, digit_d, adj;

  // add-3 correction before each shift
  always_comb begin
    adj = (digit_q >= b2da_pkg::AdjLimit) ? (digit_q + b2da_pkg::AdjAdd) : digit_q;
  end

  always_comb begin
    digit_d = digit_q;
    priority if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[b2da_pkg::DigitW-2:0], bit_i};
    end else if (ctrl_i.emit) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign bit_o   = adj[b2da_pkg::DigitW-1];
  assign digit_o = digit_q;

endmodule

FILE: rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter, 64-bit, double dabble.
// Input: start_i with in_i (value, is_signed); a transfer happens at a rising
// edge where start_i is high and busy_o is low. busy_o stays high while the
// item is converted and its text is sent.
// Output: at most one character per cycle on res_o, marked by res_valid_o for exactly
// one cycle; res_o.last flags the final character of the number. Digits come
// most significant first, without leading zeros; a negative signed value is
// preceded by '-'. Zero gives the single character '0'.
// Sequence: '-' (if any) appears in the cycle after the transfer; then 64
// shift steps through the row of 20 BCD digit cells, then 20 steps in which the
// row shifts toward the top digit, one digit examined per cycle (leading
// zeros are dropped, not sent). A new item can be taken in the cycle after
// busy_o falls, the cycle in which the last character is shown.
// The receiver cannot stall: every strobed character must be taken.
// Reset (rst_ni, asynchronous, active low) returns the block to idle with no
// character pending.
module binary_to_decimal_ascii (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  b2da_pkg::b2da_in_t  in_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output b2da_pkg::b2da_out_t res_o
);

  localparam int unsigned N = b2da_pkg::NumDigits;

  b2da_pkg::b2da_state_e state_q, state_d;
  logic [b2da_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [b2da_pkg::ValueW-1:0] mag_q, mag_d;
  logic                        seen_q, seen_d;
  logic                        res_valid_q, res_valid_d;
  b2da_pkg::b2da_out_t         res_q, res_d;
  logic                        accept;
  logic                        neg;
  logic [b2da_pkg::ValueW-1:0] mag_in;
  logic [b2da_pkg::DigitW-1:0] top_digit;
  logic                        emit_now;
  b2da_pkg::cell_ctrl_t        ctrl;

  logic                        carry [N];
  logic [b2da_pkg::DigitW-1:0] digit [N];

  assign accept = start_i && (state_q == b2da_pkg::StIdle);
  assign neg    = in_i.is_signed && in_i.value[b2da_pkg::ValueW-1];
  assign mag_in = neg ? (~in_i.value + 64'd1) : in_i.value;

  assign ctrl.clr  = accept;
  assign ctrl.conv = (state_q == b2da_pkg::StConv);
  assign ctrl.emit = (state_q == b2da_pkg::StEmit);

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                        bit_in;
    logic [b2da_pkg::DigitW-1:0] dig_in;
    if (i == 0) begin : g_first
      assign bit_in = mag_q[b2da_pkg::ValueW-1];
      assign dig_in = '0;
    end else begin : g_rest
      assign bit_in = carry[i-1];
      assign dig_in = digit[i-1];
    end
    if (i == N - 1) begin : g_top
      b2da_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .bit_i   (bit_in),
        .digit_i (dig_in),
        .bit_o   (),
        .digit_o (digit[i])
      );
    end else begin : g_mid
      b2da_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .bit_i   (bit_in),
        .digit_i (dig_in),
        .bit_o   (carry[i]),
        .digit_o (digit[i])
      );
    end
  end

  assign top_digit = digit[N-1];
  assign emit_now  = (top_digit != '0) || seen_q || (cnt_q == b2da_pkg::EmitLast);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    seen_d      = seen_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      b2da_pkg::StIdle: begin
        if (start_i) begin
          state_d         = b2da_pkg::StConv;
          cnt_d           = '0;
          mag_d           = mag_in;
          seen_d          = 1'b0;
          res_valid_d     = neg;
          res_d.text_char = b2da_pkg::CharMinus;
          res_d.last      = 1'b0;
        end
      end
      b2da_pkg::StConv: begin
        mag_d = {mag_q[b2da_pkg::ValueW-2:0], 1'b0};
        if (cnt_q == b2da_pkg::ConvLast) begin
          state_d = b2da_pkg::StEmit;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + b2da_pkg::CntW'(1);
        end
      end
      b2da_pkg::StEmit: begin
        res_valid_d     = emit_now;
        res_d.text_char = b2da_pkg::CharZero + {2'b00, top_digit};
        res_d.last      = (cnt_q == b2da_pkg::EmitLast);
        seen_d          = emit_now;
        if (cnt_q == b2da_pkg::EmitLast) begin
          state_d = b2da_pkg::StIdle;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + b2da_pkg::CntW'(1);
        end
      end
      default: begin
        state_d = b2da_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= b2da_pkg::StIdle;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != b2da_pkg::StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/b2da_checker.sv
module b2da_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input b2da_pkg::b2da_in_t  in_i,
  input logic                busy_o,
  input logic                res_valid_o,
  input b2da_pkg::b2da_out_t res_o
);

  logic in_xfer;
  logic is_minus;
  logic is_digit;

  assign in_xfer  = start_i && !busy_o;
  assign is_minus = (res_o.text_char == b2da_pkg::CharMinus);
  assign is_digit = (res_o.text_char >= b2da_pkg::CharZero) &&
                    (res_o.text_char <= b2da_pkg::CharNine);

  a_busy_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_o)
    else $error("busy not raised after input transfer");

  a_only_minus_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (!res_valid_o || (is_minus && !res_o.last && !$past(in_i.value[63]) == 1'b0)))
    else $error("unexpected character right after input transfer");

  a_char_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (is_minus || is_digit))
    else $error("character out of range");

  a_minus_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && is_minus) |-> !res_o.last)
    else $error("minus sign flagged as last");

  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy_o)
    else $error("busy still high with last character");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

FILE: dv/binary_to_decimal_ascii_tb.sv
module binary_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned MaxReports = 10;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  b2da_pkg::b2da_in_t  in_i = '0;
  logic                busy_o;
  logic                res_valid_o;
  b2da_pkg::b2da_out_t res_o;

  b2da_pkg::b2da_in_t  value_q[$];
  b2da_pkg::b2da_out_t text_q[$];
  logic        took = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned items_taken = 0;
  int unsigned neg_items = 0;
  int unsigned chars_seen = 0;

  binary_to_decimal_ascii u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pow10(int unsigned k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return p;
  endfunction

  // expected characters of one number, most significant digit first
  function automatic void queue_decimal_text(b2da_pkg::b2da_in_t item);
    logic [63:0]         mag;
    logic [3:0]          digit [b2da_pkg::NumDigits];
    int                  n;
    logic                neg;
    b2da_pkg::b2da_out_t ch;
    neg = item.is_signed && item.value[b2da_pkg::ValueW-1];
    mag = neg ? (~item.value + 64'd1) : item.value;
    n = 0;
    do begin
      digit[n] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
      n++;
    end while (mag != 64'd0);
    if (neg) begin
      ch.text_char = b2da_pkg::CharMinus;
      ch.last = 1'b0;
      text_q.push_back(ch);
      neg_items++;
    end
    for (int i = n - 1; i >= 0; i--) begin
      ch.text_char = b2da_pkg::CharZero + 6'(digit[i]);
      ch.last = (i == 0);
      text_q.push_back(ch);
    end
  endfunction

  function automatic void add_item(logic [63:0] v, logic s);
    b2da_pkg::b2da_in_t it;
    it.value = v;
    it.is_signed = s;
    value_q.push_back(it);
  endfunction

  function automatic b2da_pkg::b2da_in_t random_item();
    b2da_pkg::b2da_in_t it;
    int unsigned        w;
    int unsigned        k;
    logic [63:0]        v;
    it.is_signed = 1'($urandom_range(1, 0));
    w = $urandom_range(64, 1);
    k = $urandom_range(19, 0);
    case ($urandom_range(7, 0))
      0: v = pow10(k) - 64'($urandom_range(1, 0));
      1: v = rand64();
      default: v = rand64() >> (64 - w);
    endcase
    // negate the value for about half of the signed items
    if (it.is_signed && $urandom_range(1, 0) == 1) begin
      v = ~v + 64'd1;
    end
    it.value = v;
    return it;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (took) begin
      void'(value_q.pop_front());
    end
    if (start_i && !took) begin
      start_i <= 1'b1;
    end else if (value_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
      start_i <= 1'b1;
      in_i    <= value_q[0];
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    b2da_pkg::b2da_out_t want;
    logic                xfer;
    xfer = rst_ni && start_i && !busy_o;
    took <= xfer;
    if (xfer) begin
      queue_decimal_text(in_i);
      items_taken++;
    end
    if (rst_ni && res_valid_o) begin
      chars_seen++;
      if (text_q.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("%0t: unexpected character 0x%0h last=%0b", $realtime,
                   res_o.text_char, res_o.last);
        end
        mismatches++;
      end else begin
        want = text_q.pop_front();
        if (res_o.text_char !== want.text_char || res_o.last !== want.last) begin
          if (mismatches < MaxReports) begin
            $display("%0t: char expected 0x%0h last=%0b, got 0x%0h last=%0b", $realtime,
                     want.text_char, want.last, res_o.text_char, res_o.last);
          end
          mismatches++;
        end
      end
    end
    if (xfer || (rst_ni && res_valid_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles", QuietLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      // no idling, sender idle 65, no idling again (receiver cannot stall), mixed 25
      case (ph)
        1:       idle_pct = 65;
        3:       idle_pct = 25;
        default: idle_pct = 0;
      endcase
      if (ph == 0) begin
        add_item(64'd0, 1'b0);
        add_item(64'd0, 1'b1);
        add_item(64'd1, 1'b0);
        add_item(64'd9, 1'b1);
        add_item(64'd10, 1'b0);
        add_item(64'd99, 1'b0);
        add_item(64'd100, 1'b1);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        add_item(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        add_item(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
        add_item(64'h8000_0000_0000_0000, 1'b1);
        add_item(64'h8000_0000_0000_0000, 1'b0);
        add_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        add_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(pow10(19), 1'b0);
        add_item(pow10(19) - 64'd1, 1'b0);
        add_item(pow10(18), 1'b1);
        add_item(~pow10(18) + 64'd1, 1'b1);
        add_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_item(64'h5555_5555_5555_5555, 1'b1);
        add_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      end
      repeat (32) value_q.push_back(random_item());
      while (value_q.size() != 0 || text_q.size() != 0) @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (text_q.size() != 0) begin
      $display("%0d expected characters never arrived", text_q.size());
      mismatches += text_q.size();
    end
    $display("converted %0d numbers (%0d negative in signed mode), checked %0d characters",
             items_taken, neg_items, chars_seen);
    $display("pacing: back to back, sparse and mixed start gaps; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/b2da_pkg.sv
rtl/b2da_cell.sv
rtl/binary_to_decimal_ascii.sv
rtl/b2da_checker.sv
dv/binary_to_decimal_ascii_tb.sv
